// ----- rtl/anagram_window_matcher_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the anagram window matcher checker
// ---------------------------------------------------------------------------
`ifndef ANAGRAM_WINDOW_MATCHER_ASSERT_SVH
`define ANAGRAM_WINDOW_MATCHER_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle while rst_n is low
`define AWM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("awm: same-cycle check failed");

// Next-cycle implication, sampled on clk, idle while rst_n is low
`define AWM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("awm: next-cycle check failed");

`endif

// ----- rtl/awm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// awm_pkg
// Shared types and constants of the anagram window matcher.
// ---------------------------------------------------------------------------
package awm_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int LETTER_W      = 5;
    localparam int CMD_W         = 2;

    typedef logic [LETTER_W-1:0] letter_t;

    // Command codes; the fourth code changes no state but still yields a result
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_TEXT  = 2'd2
    } cmd_t;

    // Per-bin update strobes
    typedef struct packed {
        logic clear;
        logic pat_inc;
        logic win_inc;
        logic win_dec;
    } bin_ctrl_t;

    // What the compare stage needs to know about a transfer in flight
    typedef struct packed {
        logic is_text;
        logic is_clear;
        logic full;
    } res_info_t;

endpackage

// ----- rtl/awm_tap_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// awm_tap_cell
// One stage of the letter delay line; offers its letter when selected.
// ---------------------------------------------------------------------------
module awm_tap_cell (
    input  logic            clk,
    input  logic            shift_en,
    input  logic            sel,
    input  awm_pkg::letter_t letter_in,
    output awm_pkg::letter_t letter_out,
    output awm_pkg::letter_t tap_out
);

    awm_pkg::letter_t letter_reg;
    awm_pkg::letter_t letter_next;

    // shift on every text letter
    always_comb
    begin
        letter_next = shift_en ? letter_in : letter_reg;
    end

    always_ff @(posedge clk)
    begin
        letter_reg <= letter_next;
    end

    assign letter_out = letter_reg;
    // zero when not selected so the taps can be OR-ed together
    assign tap_out    = sel ? letter_reg : '0;

endmodule

// ----- rtl/awm_bin_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// awm_bin_cell
// One alphabet bin: pattern count, window count and their equality.
// ---------------------------------------------------------------------------
module awm_bin_cell #(
    parameter int CNT_W = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  awm_pkg::bin_ctrl_t ctrl,
    output logic               eq
);

    logic [CNT_W-1:0] pat_cnt_reg;
    logic [CNT_W-1:0] pat_cnt_next;
    logic [CNT_W-1:0] win_cnt_reg;
    logic [CNT_W-1:0] win_cnt_next;
    logic             do_dec;

    // count update; the window count never goes below zero
    always_comb
    begin
        do_dec       = ctrl.win_dec && (win_cnt_reg != '0);
        pat_cnt_next = pat_cnt_reg;
        win_cnt_next = win_cnt_reg;
        priority if (ctrl.clear)
        begin
            pat_cnt_next = '0;
            win_cnt_next = '0;
        end
        else
        begin
            if (ctrl.pat_inc)
            begin
                pat_cnt_next = pat_cnt_reg + 1'b1;
            end
            if (ctrl.win_inc && !do_dec)
            begin
                win_cnt_next = win_cnt_reg + 1'b1;
            end
            else if (!ctrl.win_inc && do_dec)
            begin
                win_cnt_next = win_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_cnt_reg <= '0;
            win_cnt_reg <= '0;
        end
        else
        begin
            pat_cnt_reg <= pat_cnt_next;
            win_cnt_reg <= win_cnt_next;
        end
    end

    assign eq = (pat_cnt_reg == win_cnt_reg);

endmodule

// ----- rtl/anagram_window_matcher.sv -----
`timescale 1ns / 1ps
// Each input transfer first updates the bins and lengths, then passes the compare stage into the output register.
// Throughput: one item per cycle while in_ready is high; the delay line and all bins update together on a transfer.
// Input stalls only while both the compare stage and the output register are held.
// Reset (rst_n low, asynchronous) empties both histograms, lengths and the found flag.
// The delay line letters are not reset; only letters shifted in since a clear are read.
// ---------------------------------------------------------------------------
// anagram_window_matcher
// Sliding-window anagram search over a letter stream with a tapped delay line.
// ---------------------------------------------------------------------------
module anagram_window_matcher #(
    parameter int PATTERN_MAX = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [awm_pkg::CMD_W-1:0]   command,
    input  awm_pkg::letter_t            letter,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        match,
    output logic                        found,
    output logic                        window_full
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam awm_pkg::letter_t ALPHA_LIM = awm_pkg::letter_t'(awm_pkg::ALPHABET_SIZE);

    awm_pkg::cmd_t             cmd;
    logic                      in_fire;
    logic                      s2_adv;

    logic [LEN_W-1:0]          len_reg;
    logic [LEN_W-1:0]          len_next;
    logic [LEN_W-1:0]          seen_reg;
    logic [LEN_W-1:0]          seen_next;

    logic                      clr;
    logic                      do_load;
    logic                      do_text;
    logic                      do_drop;
    logic                      shift_en;

    logic [PATTERN_MAX-1:0]    tap_sel;
    awm_pkg::letter_t          chain   [PATTERN_MAX+1];
    awm_pkg::letter_t          taps    [PATTERN_MAX];
    awm_pkg::letter_t          drop_letter;

    logic [awm_pkg::ALPHABET_SIZE-1:0] bin_eq;
    logic                      hist_eq;

    logic                      s2_valid_reg;
    logic                      s2_valid_next;
    awm_pkg::res_info_t        s2_info_reg;
    awm_pkg::res_info_t        s2_info_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      match_reg;
    logic                      match_next;
    logic                      full_reg;
    logic                      full_next;
    logic                      found_reg;
    logic                      found_next;

    assign cmd     = awm_pkg::cmd_t'(command);
    assign s2_adv  = s2_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s2_valid_reg || !out_valid_reg || out_ready;
    assign in_fire = in_valid && in_ready;

    // command decode and length bookkeeping
    always_comb
    begin
        len_next  = len_reg;
        seen_next = seen_reg;
        clr       = 1'b0;
        do_load   = 1'b0;
        do_text   = 1'b0;
        do_drop   = 1'b0;
        shift_en  = 1'b0;
        if (in_fire)
        begin
            unique case (cmd)
                awm_pkg::CMD_CLEAR:
                begin
                    clr       = 1'b1;
                    len_next  = '0;
                    seen_next = '0;
                end
                awm_pkg::CMD_LOAD:
                begin
                    if ((letter < ALPHA_LIM) && (len_reg != LEN_W'(PATTERN_MAX)))
                    begin
                        do_load  = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                end
                awm_pkg::CMD_TEXT:
                begin
                    shift_en = 1'b1;
                    if (len_reg != '0)
                    begin
                        do_text = 1'b1;
                        if (seen_reg == len_reg)
                        begin
                            do_drop = 1'b1;
                        end
                        else
                        begin
                            seen_next = seen_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // delay line: cell k holds the letter k+1 text transfers back
    assign chain[0] = letter;

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_tap
        assign tap_sel[k] = (len_reg == LEN_W'(k + 1));

        awm_tap_cell u_tap (
            .clk        (clk),
            .shift_en   (shift_en),
            .sel        (tap_sel[k]),
            .letter_in  (chain[k]),
            .letter_out (chain[k+1]),
            .tap_out    (taps[k])
        );
    end

    // letter leaving the window
    always_comb
    begin
        drop_letter = '0;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            drop_letter = drop_letter | taps[k];
        end
    end

    // alphabet bins
    for (genvar b = 0; b < awm_pkg::ALPHABET_SIZE; b++)
    begin : g_bin
        awm_pkg::bin_ctrl_t bin_ctrl;

        assign bin_ctrl.clear   = clr;
        assign bin_ctrl.pat_inc = do_load && (letter == awm_pkg::letter_t'(b));
        assign bin_ctrl.win_inc = do_text && (letter == awm_pkg::letter_t'(b));
        assign bin_ctrl.win_dec = do_drop && (drop_letter == awm_pkg::letter_t'(b));

        awm_bin_cell #(
            .CNT_W (LEN_W)
        ) u_bin (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (bin_ctrl),
            .eq    (bin_eq[b])
        );
    end

    assign hist_eq = &bin_eq;

    // compare stage: bins already hold the post-update state of its transfer
    always_comb
    begin
        s2_info_next.is_text  = (cmd == awm_pkg::CMD_TEXT);
        s2_info_next.is_clear = (cmd == awm_pkg::CMD_CLEAR);
        s2_info_next.full     = (seen_next == len_next);

        if (in_fire)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_next = 1'b0;
        end
        else
        begin
            s2_valid_next = s2_valid_reg;
        end
    end

    // result and sticky flag
    always_comb
    begin
        match_next     = match_reg;
        full_next      = full_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (s2_adv)
        begin
            match_next     = s2_info_reg.is_text && s2_info_reg.full && hist_eq;
            full_next      = s2_info_reg.full;
            found_next     = !s2_info_reg.is_clear && (found_reg || match_next);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            seen_reg      <= '0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            seen_reg      <= seen_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s2_info_reg <= s2_info_next;
        end
        match_reg <= match_next;
        full_reg  <= full_next;
    end

    assign out_valid   = out_valid_reg;
    assign match       = match_reg;
    assign found       = found_reg;
    assign window_full = full_reg;

endmodule

// ----- rtl/awm_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// awm_checker
// Port-level checks on the result channel of the anagram window matcher.
// ---------------------------------------------------------------------------
`include "anagram_window_matcher_assert.svh"

module awm_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic match,
    input logic found,
    input logic window_full
);

    // a match needs a full window
    `AWM_ASSERT_IMP(a_match_full, out_valid && match, window_full)

    // a match always raises the sticky flag
    `AWM_ASSERT_IMP(a_match_found, out_valid && match, found)

    // a stalled result holds
    `AWM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({match, found, window_full}))

endmodule

bind anagram_window_matcher awm_checker u_awm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .match       (match),
    .found       (found),
    .window_full (window_full)
);
